// ----- rtl/core/fnvkt_pkg.sv -----
// Shared types, constants and hash step for the FNV linear-probe key table.
package fnvkt_pkg;

  // Default sizes
  localparam int unsigned SLOT_COUNT_DEF     = 4096;
  localparam int unsigned ENTRY_CAPACITY_DEF = 2048;
  localparam int unsigned KEY_BYTES_DEF      = 16;

  // Fixed field widths
  localparam int unsigned KEY_LEN_W   = 5;
  localparam int unsigned ENTRY_NUM_W = 11;

  // FNV-1a 64 prime and a start basis that is not the standard offset basis; the prime is 2^40 + 2^8 + 0xB3
  localparam logic [63:0] FNV_BASIS     = 64'd1469598103934665603;
  localparam logic [7:0]  FNV_PRIME_LOW = 8'hB3;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef struct packed {
    logic                 kind;
    logic [63:0]          key_low;
    logic [63:0]          key_high;
    logic [KEY_LEN_W-1:0] key_length;
  } cmd_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [ENTRY_NUM_W-1:0] entry_number;
  } result_t;

  // One FNV-1a byte step: xor the byte in, multiply by the prime as shifts and adds
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x * {56'd0, FNV_PRIME_LOW});
  endfunction

endpackage

// ----- rtl/core/fnv_linear_probe_key_table_unit.sv -----
// Top level of the FNV-1a hashed, linearly probed exact-match key table.
//
//   channel   handshake          payload
//   command   start / busy       cmd_i    (fnvkt_pkg::cmd_t)
//   result    done_o strobe      result_o (fnvkt_pkg::result_t)
//
// A command is hashed byte by byte, then folded and reduced by reciprocal when
// SLOT_COUNT is not a power of two, and handed over to the queue; the back end then
// checks each probed slot for an insert and also compares the stored key of each
// occupied slot for a lookup, reading slot and key memories over one registered
// port each.
// After reset the slot table is swept clear with busy high.
// The two-entry queue lets the next command hash while the back end probes;
// each result is shown for one cycle on done_o and cannot be held off.
module fnv_linear_probe_key_table_unit #(
  parameter int unsigned SLOT_COUNT     = fnvkt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned ENTRY_CAPACITY = fnvkt_pkg::ENTRY_CAPACITY_DEF,
  parameter int unsigned KEY_BYTES      = fnvkt_pkg::KEY_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  fnvkt_pkg::cmd_t    cmd_i,
  output logic               done_o,
  output fnvkt_pkg::result_t result_o
);

  localparam int unsigned SW = $clog2(SLOT_COUNT);
  localparam int unsigned KW = KEY_BYTES * 8;
  localparam int unsigned LW = fnvkt_pkg::KEY_LEN_W;
  localparam int unsigned QW = 1 + KW + LW + SW;

  logic          push, full, empty, pop, clearing;
  logic          f_kind, b_kind;
  logic [KW-1:0] f_key, b_key;
  logic [LW-1:0] f_len, b_len;
  logic [SW-1:0] f_slot, b_slot;
  logic [QW-1:0] q_out;

  fnvkt_front #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BYTES  (KEY_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_i   (cmd_i),
    .block_i (clearing),
    .busy_o  (busy),
    .push_o  (push),
    .kind_o  (f_kind),
    .key_o   (f_key),
    .len_o   (f_len),
    .slot_o  (f_slot),
    .full_i  (full)
  );

  fnvkt_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_kind, f_key, f_len, f_slot}),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (q_out)
  );

  assign {b_kind, b_key, b_len, b_slot} = q_out;

  fnvkt_back #(
    .SLOT_COUNT     (SLOT_COUNT),
    .ENTRY_CAPACITY (ENTRY_CAPACITY),
    .KEY_BYTES      (KEY_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .kind_i     (b_kind),
    .key_i      (b_key),
    .len_i      (b_len),
    .slot_i     (b_slot),
    .clearing_o (clearing),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

// ----- rtl/core/fnvkt_front.sv -----
// Front end: accepts a command, masks the key, hashes it and reduces it to a start slot.
module fnvkt_front #(
  parameter int unsigned SLOT_COUNT = fnvkt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned KEY_BYTES  = fnvkt_pkg::KEY_BYTES_DEF,
  localparam int unsigned SW   = $clog2(SLOT_COUNT),
  localparam int unsigned KW   = KEY_BYTES * 8,
  localparam int unsigned LW   = fnvkt_pkg::KEY_LEN_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fnvkt_pkg::cmd_t   cmd_i,
  input  logic              block_i,
  output logic              busy_o,
  output logic              push_o,
  output logic              kind_o,
  output logic [KW-1:0]     key_o,
  output logic [LW-1:0]     len_o,
  output logic [SW-1:0]     slot_o,
  input  logic              full_i
);

  localparam bit IsPow2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
  // 2^32 reduced by the slot count, and the truncated reciprocal 2^32 / SLOT_COUNT
  localparam logic [31:0] FoldR = 32'((64'd1 << 32) % 64'(SLOT_COUNT));
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'(SLOT_COUNT));

  typedef enum logic [5:0] {
    H_IDLE = 6'b000001,
    H_HASH = 6'b000010,
    H_FOLD = 6'b000100,
    H_QUOT = 6'b001000,
    H_FIX  = 6'b010000,
    H_HOLD = 6'b100000
  } hstate_e;

  hstate_e       state_q, state_d;
  logic          kind_q;
  logic [KW-1:0] key_q, shift_q, shift_d;
  logic [LW-1:0] len_q, cnt_q, cnt_d;
  logic [63:0]   hash_q, hash_d;
  logic [SW-1:0] rem_q, rem_d;
  logic [31:0]   quot_q, quot_d;
  logic          accept;
  logic [LW-1:0] len_sat;
  logic [KW-1:0] key_masked;
  logic [127:0]  key_full;
  logic [63:0]   prod;
  logic [31:0]   fix;

  assign accept = start_i && (state_q == H_IDLE) && !block_i;
  assign busy_o = (state_q != H_IDLE) || block_i;

  // Saturate the length and drop bytes past it
  always_comb begin
    len_sat  = (cmd_i.key_length > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : cmd_i.key_length;
    key_full = {cmd_i.key_high, cmd_i.key_low};
    for (int i = 0; i < KEY_BYTES; i++) begin
      key_masked[i*8 +: 8] = (LW'(i) < len_sat) ? key_full[i*8 +: 8] : 8'd0;
    end
  end

  // Hash one byte a cycle, then take the low bits for a power-of-two slot count, else fold and reduce by reciprocal
  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    prod    = '0;
    fix     = '0;
    case (state_q)
      H_IDLE: begin
        if (accept) begin
          shift_d = key_masked;
          cnt_d   = len_sat;
          hash_d  = fnvkt_pkg::FNV_BASIS;
          state_d = H_HASH;
        end
      end
      H_HASH: begin
        if (cnt_q == '0) begin
          if (IsPow2) begin
            rem_d   = hash_q[SW-1:0];
            state_d = H_HOLD;
          end else begin
            state_d = H_FOLD;
          end
        end else begin
          hash_d  = fnvkt_pkg::fnv_step(hash_q, shift_q[7:0]);
          shift_d = shift_q >> 8;
          cnt_d   = cnt_q - LW'(1);
        end
      end
      // Fold the upper word down until the value fits 32 bits
      H_FOLD: begin
        if (hash_q[63:32] != '0) begin
          hash_d = (hash_q[63:32] * FoldR) + {32'd0, hash_q[31:0]};
        end else begin
          prod    = hash_q[31:0] * Recip;
          quot_d  = prod[63:32];
          state_d = H_QUOT;
        end
      end
      // Subtract the estimated multiple; the remainder is below twice the slot count
      H_QUOT: begin
        hash_d  = {32'd0, hash_q[31:0] - quot_q * 32'(SLOT_COUNT)};
        state_d = H_FIX;
      end
      H_FIX: begin
        fix     = (hash_q[31:0] >= 32'(SLOT_COUNT)) ? hash_q[31:0] - 32'(SLOT_COUNT)
                                                     : hash_q[31:0];
        rem_d   = fix[SW-1:0];
        state_d = H_HOLD;
      end
      H_HOLD: begin
        if (!full_i) begin
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  assign push_o = (state_q == H_HOLD) && !full_i;
  assign kind_o = kind_q;
  assign key_o  = key_q;
  assign len_o  = len_q;
  assign slot_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the command and the working values
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= cmd_i.kind;
      key_q  <= key_masked;
      len_q  <= len_sat;
    end
    shift_q <= shift_d;
    cnt_q   <= cnt_d;
    hash_q  <= hash_d;
    rem_q   <= rem_d;
    quot_q  <= quot_d;
  end

endmodule

// ----- rtl/core/fnvkt_queue.sv -----
// Two-entry queue between the hash front end and the probe back end.
module fnvkt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/fnvkt_back.sv -----
// Back end: clears the slot table, probes it linearly and stores or matches keys.
module fnvkt_back #(
  parameter int unsigned SLOT_COUNT     = fnvkt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned ENTRY_CAPACITY = fnvkt_pkg::ENTRY_CAPACITY_DEF,
  parameter int unsigned KEY_BYTES      = fnvkt_pkg::KEY_BYTES_DEF,
  localparam int unsigned SW = $clog2(SLOT_COUNT),
  localparam int unsigned PW = $clog2(SLOT_COUNT + 1),
  localparam int unsigned EW = $clog2(ENTRY_CAPACITY),
  localparam int unsigned CW = $clog2(ENTRY_CAPACITY + 1),
  localparam int unsigned KW = KEY_BYTES * 8,
  localparam int unsigned LW = fnvkt_pkg::KEY_LEN_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  output logic                 pop_o,
  input  logic                 kind_i,
  input  logic [KW-1:0]        key_i,
  input  logic [LW-1:0]        len_i,
  input  logic [SW-1:0]        slot_i,
  output logic                 clearing_o,
  output logic                 done_o,
  output fnvkt_pkg::result_t   result_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SLOT = 4'b0010,
    B_SCHK = 4'b0100,
    B_KCHK = 4'b1000
  } bstate_e;

  bstate_e          state_q, state_d;
  logic             clr_q;
  logic [SW-1:0]    clr_addr_q;
  logic             kind_q;
  logic [LW+KW-1:0] key_q;
  logic [SW-1:0]    pos_q, pos_d, pos_next;
  logic [PW-1:0]    probe_q, probe_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ld;
  logic             last_probe;

  // Slot memory: valid bit over entry index
  logic [EW:0]      slot_mem [SLOT_COUNT];
  logic [EW:0]      slot_rd_q;
  logic             slot_we;
  logic [SW-1:0]    slot_wa;
  logic [EW:0]      slot_wd;
  logic             ins_we;

  // Key memory: length over key bytes
  logic [LW+KW-1:0] key_mem [ENTRY_CAPACITY];
  logic [LW+KW-1:0] key_rd_q;

  logic                   done_d;
  fnvkt_pkg::status_e     st_d;
  logic [EW-1:0]          num_d;
  fnvkt_pkg::result_t     res_q;
  logic                   done_q;

  assign clearing_o = clr_q;
  assign pos_next   = (pos_q == SW'(SLOT_COUNT - 1)) ? '0 : pos_q + SW'(1);
  assign last_probe = probe_q == PW'(SLOT_COUNT - 1);

  // Sequence the probe
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    probe_d = probe_q;
    count_d = count_q;
    ld      = 1'b0;
    ins_we  = 1'b0;
    done_d  = 1'b0;
    st_d    = fnvkt_pkg::ST_NOT_FOUND;
    num_d   = '0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i && !clr_q) begin
          ld = 1'b1;
          if (kind_i == fnvkt_pkg::KIND_INSERT && count_q == CW'(ENTRY_CAPACITY)) begin
            done_d = 1'b1;
            st_d   = fnvkt_pkg::ST_FULL;
          end else begin
            pos_d   = slot_i;
            probe_d = '0;
            state_d = B_SLOT;
          end
        end
      end
      B_SLOT: state_d = B_SCHK;
      B_SCHK: begin
        if (!slot_rd_q[EW]) begin
          done_d  = 1'b1;
          state_d = B_IDLE;
          if (kind_q == fnvkt_pkg::KIND_INSERT) begin
            ins_we  = 1'b1;
            st_d    = fnvkt_pkg::ST_INSERTED;
            num_d   = count_q[EW-1:0];
            count_d = count_q + CW'(1);
          end
        end else if (kind_q == fnvkt_pkg::KIND_LOOKUP) begin
          state_d = B_KCHK;
        end else if (last_probe) begin
          done_d  = 1'b1;
          st_d    = fnvkt_pkg::ST_FULL;
          state_d = B_IDLE;
        end else begin
          pos_d   = pos_next;
          probe_d = probe_q + PW'(1);
          state_d = B_SLOT;
        end
      end
      B_KCHK: begin
        if (key_rd_q == key_q) begin
          done_d  = 1'b1;
          st_d    = fnvkt_pkg::ST_FOUND;
          num_d   = slot_rd_q[EW-1:0];
          state_d = B_IDLE;
        end else if (last_probe) begin
          done_d  = 1'b1;
          state_d = B_IDLE;
        end else begin
          pos_d   = pos_next;
          probe_d = probe_q + PW'(1);
          state_d = B_SLOT;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign pop_o = ld;

  // Share the slot write port between clearing and inserts
  always_comb begin
    slot_we = clr_q || ins_we;
    slot_wa = clr_q ? clr_addr_q : pos_q;
    slot_wd = clr_q ? '0 : {1'b1, count_q[EW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_q <= slot_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    if (ins_we) begin
      key_mem[count_q[EW-1:0]] <= key_q;
    end
    key_rd_q <= key_mem[slot_rd_q[EW-1:0]];
  end

  // Hold control state, sweep the slot table after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      count_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + SW'(1);
        if (clr_addr_q == SW'(SLOT_COUNT - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      kind_q <= kind_i;
      key_q  <= {len_i, key_i};
    end
    pos_q   <= pos_d;
    probe_q <= probe_d;
    res_q.status       <= st_d;
    res_q.entry_number <= fnvkt_pkg::ENTRY_NUM_W'(num_d);
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the FNV-1a linear-probe key table, checked against its own table model.
module testbench;

  localparam int unsigned SLOTS    = fnvkt_pkg::SLOT_COUNT_DEF;
  localparam int unsigned CAPACITY = fnvkt_pkg::ENTRY_CAPACITY_DEF;
  localparam int unsigned KBYTES   = fnvkt_pkg::KEY_BYTES_DEF;
  localparam logic [63:0] PRIME    = 64'd1099511628211;

  // Table model and queue of predicted results
  class key_table_board;
    logic [11:0]  slot_entry [SLOTS];
    bit           slot_used  [SLOTS];
    logic [63:0]  stored_low [CAPACITY];
    logic [63:0]  stored_high[CAPACITY];
    logic [4:0]   stored_len [CAPACITY];
    int unsigned  entries;
    fnvkt_pkg::result_t pending[$];
    int unsigned  n_errors;
    int unsigned  n_checked;
    int unsigned  n_found;
    int unsigned  n_full;

    function void clear();
      foreach (slot_used[i]) slot_used[i] = 0;
      entries = 0;
    endfunction

    function logic [63:0] byte_mask(int unsigned n);
      if (n >= 8) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Work out the status and entry for an accepted command
    function void note_command(fnvkt_pkg::cmd_t c);
      int unsigned len;
      int unsigned pos;
      int unsigned e;
      logic [63:0] lo, hi, h;
      fnvkt_pkg::result_t r;
      len = (c.key_length > KBYTES) ? KBYTES : c.key_length;
      lo = c.key_low & byte_mask(len);
      hi = (len > 8) ? (c.key_high & byte_mask(len - 8)) : 64'd0;
      h = fnvkt_pkg::FNV_BASIS;
      for (int i = 0; i < len; i++) begin
        h = h ^ {56'd0, (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8]};
        h = h * PRIME;
      end
      pos = 32'(h % SLOTS);
      r.status = fnvkt_pkg::ST_NOT_FOUND;
      r.entry_number = '0;
      if (c.kind == fnvkt_pkg::KIND_INSERT) begin
        r.status = fnvkt_pkg::ST_FULL;
        if (entries < CAPACITY) begin
          for (int p = 0; p < SLOTS; p++) begin
            if (!slot_used[pos]) begin
              stored_low[entries] = lo;
              stored_high[entries] = hi;
              stored_len[entries] = 5'(len);
              slot_entry[pos] = 12'(entries);
              slot_used[pos] = 1;
              r.status = fnvkt_pkg::ST_INSERTED;
              r.entry_number = 11'(entries);
              entries++;
              break;
            end
            pos = (pos + 1) % SLOTS;
          end
        end
      end else begin
        for (int p = 0; p < SLOTS; p++) begin
          if (!slot_used[pos]) break;
          e = slot_entry[pos];
          if (e < CAPACITY && stored_len[e] == len && stored_low[e] == lo &&
              stored_high[e] == hi) begin
            r.status = fnvkt_pkg::ST_FOUND;
            r.entry_number = 11'(e);
            break;
          end
          pos = (pos + 1) % SLOTS;
        end
      end
      if (r.status == fnvkt_pkg::ST_FOUND) n_found++;
      if (r.status == fnvkt_pkg::ST_FULL) n_full++;
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("tb: mismatch: %s", what);
      n_errors++;
    endtask

    // Compare one strobed result with the oldest prediction
    task check_result(fnvkt_pkg::result_t got);
      fnvkt_pkg::result_t want;
      n_checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d entry=%0d",
                         got.status, got.entry_number));
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.entry_number !== want.entry_number)
        report($sformatf("entry got %0d want %0d", got.entry_number, want.entry_number));
    endtask
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  fnvkt_pkg::cmd_t    cmd_i;
  logic    done_o;
  fnvkt_pkg::result_t result_o;

  key_table_board board;
  bit          gaps_on;
  logic [63:0] saved_low [$];
  logic [63:0] saved_high[$];
  logic [4:0]  saved_len [$];

  fnv_linear_probe_key_table_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .cmd_i   (cmd_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Check every strobed transaction
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) board.check_result(result_o);
  end

  // Offer one command and hold it until accepted; start stays high into the next one
  task automatic send_command(input fnvkt_pkg::kind_e k, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [4:0] len);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= '{kind: k, key_low: lo, key_high: hi, key_length: len};
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_command('{kind: k, key_low: lo, key_high: hi, key_length: len});
  endtask

  // Insert a random key and remember it for later lookups
  task automatic insert_random();
    logic [63:0] lo, hi;
    logic [4:0] len;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 16));
    saved_low.push_back(lo);
    saved_high.push_back(hi);
    saved_len.push_back(len);
    send_command(fnvkt_pkg::KIND_INSERT, lo, hi, len);
  endtask

  // Look up a saved key, with its upper bytes randomized now and then; insert one if none is saved
  task automatic lookup_known();
    int unsigned i;
    logic [63:0] lo, hi;
    if (saved_low.size() == 0) begin
      insert_random();
      return;
    end
    i = $urandom_range(0, saved_low.size() - 1);
    lo = saved_low[i];
    hi = saved_high[i];
    if ($urandom_range(0, 3) == 0) begin
      hi = {$urandom, $urandom};
      if (saved_len[i] < 8) lo[63:8] = 56'({$urandom, $urandom});
    end
    send_command(fnvkt_pkg::KIND_LOOKUP, lo, hi, saved_len[i]);
  endtask

  initial begin
    int unsigned cycles_left;
    board = new();
    board.clear();
    gaps_on = 1'b1;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty key, extremes, overlong length, duplicates, missing keys
    send_command(fnvkt_pkg::KIND_LOOKUP, '0, '0, 5'd0);
    send_command(fnvkt_pkg::KIND_INSERT, '0, '0, 5'd0);
    send_command(fnvkt_pkg::KIND_LOOKUP, '1, '1, 5'd0);
    send_command(fnvkt_pkg::KIND_INSERT, '1, '1, 5'd16);
    send_command(fnvkt_pkg::KIND_LOOKUP, '1, '1, 5'd31);
    send_command(fnvkt_pkg::KIND_INSERT, '1, '1, 5'd31);
    send_command(fnvkt_pkg::KIND_LOOKUP, '1, '0, 5'd16);
    send_command(fnvkt_pkg::KIND_LOOKUP, '1, '1, 5'd16);
    send_command(fnvkt_pkg::KIND_INSERT, 64'h0123_4567_89ab_cdef, '1, 5'd8);
    send_command(fnvkt_pkg::KIND_LOOKUP, 64'h0123_4567_89ab_cdef, '0, 5'd8);
    send_command(fnvkt_pkg::KIND_INSERT, 64'h0000_0000_0000_00a5, '0, 5'd1);
    send_command(fnvkt_pkg::KIND_LOOKUP, 64'hffff_ffff_ffff_ffa5, '1, 5'd1);
    send_command(fnvkt_pkg::KIND_LOOKUP, 64'h0000_0000_0000_00a5, '0, 5'd2);
    send_command(fnvkt_pkg::KIND_INSERT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 5'd9);
    send_command(fnvkt_pkg::KIND_LOOKUP, 64'h5555_5555_5555_5555, 64'h0000_0000_0000_00aa,
                 5'd9);
    send_command(fnvkt_pkg::KIND_LOOKUP, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab,
                 5'd15);
    send_command(fnvkt_pkg::KIND_INSERT, '0, '0, 5'd17);
    send_command(fnvkt_pkg::KIND_LOOKUP, '0, '0, 5'd16);

    // Random: mostly inserts until the entry store fills, lookups and misses mixed in
    while (board.entries < CAPACITY) begin
      if (board.entries > CAPACITY - 200) gaps_on = 1'b0;
      if ($urandom_range(0, 9) != 0) insert_random();
      else if ($urandom_range(0, 1) == 0) lookup_known();
      else send_command(fnvkt_pkg::KIND_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom},
                        5'($urandom_range(0, 31)));
    end

    // Insert into the full store, with lookups in between
    for (int n = 0; n < 20; n++) begin
      if (n % 2 == 0) insert_random();
      else lookup_known();
    end
    start <= 1'b0;

    cycles_left = 200000;
    while (board.pending.size() != 0 && cycles_left != 0) begin
      @(posedge clk_i);
      cycles_left--;
    end
    repeat (200) @(posedge clk_i);
    $display("tb: %0d results checked, %0d lookups found, %0d inserts refused as full",
             board.n_checked, board.n_found, board.n_full);
    if (board.n_errors == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Guard against a hung block
  initial begin
    #60000000;
    $display("tb: failure");
    $finish;
  end

endmodule
